/* design/stp_pkg.sv */
// Shared types, codes and helpers for the stepper move pacer.
package stp_pkg;

   // request codes
   localparam logic [1:0] REQ_MOVE = 2'd0;
   localparam logic [1:0] REQ_TICK = 2'd1;
   localparam logic [1:0] REQ_STOP = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_STEP_DELAY = 2'd0;
   localparam logic [1:0] CSR_STEPS_REV  = 2'd1;
   localparam logic [1:0] CSR_FIVE_WIRE  = 2'd2;

   localparam int DELAY_W = 24;
   localparam int POS_W   = 16;
   localparam int CNT_W   = 15;
   localparam int PHASE_W = 4;
   localparam int CSR_W   = 24;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd1000;
   localparam logic [POS_W-1:0]   REV_RESET   = 16'd200;
   localparam logic [PHASE_W-1:0] PHASE_TEN_LAST = 4'd9;

   // ceil(2^19 / 10); exact quotient for any 16-bit dividend
   localparam logic [31:0] RECIP10 = 32'd52429;

   typedef struct packed {
      logic [DELAY_W-1:0] delay;        // effective delay, never zero
      logic [POS_W-1:0]   rev_last;     // last position before wrap
      logic [PHASE_W-1:0] rev_last_m10; // rev_last mod 10
      logic               five_wire;
   } stp_cfg_type;

   typedef struct packed {
      logic               stepped;
      logic [PHASE_W-1:0] phase;
      logic               forward;
      logic               move_done;
      logic [POS_W-1:0]   moved_count;
   } stp_rsp_type;

   function automatic logic [PHASE_W-1:0] mod10(input logic [POS_W-1:0] x);
      logic [31:0]      prod;
      logic [12:0]      quo;
      logic [POS_W-1:0] quo_x10;
      logic [POS_W-1:0] rem;
      prod    = 32'(x) * RECIP10;
      quo     = prod[31:19];
      quo_x10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
      rem     = x - quo_x10;
      return rem[PHASE_W-1:0];
   endfunction

endpackage

/* design/stp_csr.sv */
// Configuration registers and the effective values derived from them.
module stp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [1:0]                      csr_index,
   input  logic [stp_pkg::CSR_W-1:0]       csr_data,
   output stp_pkg::stp_cfg_type            cfg
);

   logic [stp_pkg::DELAY_W-1:0] delay_ff;
   logic [stp_pkg::POS_W-1:0]   rev_ff;
   logic                        five_ff;
   logic [stp_pkg::POS_W-1:0]   rev_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= stp_pkg::DELAY_RESET;
         rev_ff   <= stp_pkg::REV_RESET;
         five_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            stp_pkg::CSR_STEP_DELAY: delay_ff <= csr_data;
            stp_pkg::CSR_STEPS_REV:  rev_ff   <= csr_data[stp_pkg::POS_W-1:0];
            stp_pkg::CSR_FIVE_WIRE:  five_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // zero steps per rev wraps at the full 16-bit range, so last is 0xFFFF
   assign rev_last = rev_ff - stp_pkg::POS_W'(1);

   always_comb begin
      cfg.delay        = (delay_ff == '0) ? stp_pkg::DELAY_W'(1) : delay_ff;
      cfg.rev_last     = rev_last;
      cfg.rev_last_m10 = stp_pkg::mod10(rev_last);
      cfg.five_wire    = five_ff;
   end

endmodule

/* design/stp_exec.sv */
// Move state and the per-item step decision.
module stp_exec (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [1:0]                    req_type,
   input  logic [stp_pkg::POS_W-1:0]     req_steps,
   input  stp_pkg::stp_cfg_type          cfg,
   output stp_pkg::stp_rsp_type          rsp,
   output logic                          rsp_hit
);

   logic [stp_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [stp_pkg::PHASE_W-1:0] m10_ff, m10_in;
   logic [stp_pkg::CNT_W-1:0]   remain_ff, remain_in;
   logic [stp_pkg::CNT_W-1:0]   taken_ff, taken_in;
   logic                        fwd_ff, fwd_in;
   logic [stp_pkg::DELAY_W-1:0] since_ff, since_in;
   logic                        moving_ff, moving_in;
   logic                        stop_ff, stop_in;

   logic                        neg;
   logic [stp_pkg::POS_W-1:0]   neg_steps;
   logic [stp_pkg::CNT_W-1:0]   mag;
   logic [stp_pkg::DELAY_W-1:0] since_inc;
   logic [stp_pkg::DELAY_W-1:0] since_base;
   logic [stp_pkg::CNT_W-1:0]   remain_base;
   logic [stp_pkg::CNT_W-1:0]   taken_base;
   logic                        do_step;
   logic                        done;
   logic                        fwd_wrap;
   logic                        back_wrap;
   logic [stp_pkg::POS_W-1:0]   count16;

   always_comb begin
      neg       = req_steps[stp_pkg::POS_W-1];
      neg_steps = ~req_steps + stp_pkg::POS_W'(1);
      // most negative count saturates
      if (!neg)
         mag = req_steps[stp_pkg::CNT_W-1:0];
      else if (neg_steps[stp_pkg::POS_W-1])
         mag = '1;
      else
         mag = neg_steps[stp_pkg::CNT_W-1:0];

      since_inc = (since_ff < cfg.delay) ? since_ff + stp_pkg::DELAY_W'(1) : since_ff;

      fwd_in      = fwd_ff;
      remain_base = remain_ff;
      taken_base  = taken_ff;
      moving_in   = moving_ff;
      stop_in     = stop_ff;
      since_base  = since_ff;
      do_step     = 1'b0;
      done        = 1'b0;

      unique case (req_type)
         stp_pkg::REQ_MOVE: begin
            if (!moving_ff) begin
               if (req_steps != '0)
                  fwd_in = !neg;
               taken_base = '0;
               if (stop_ff || mag == '0) begin
                  stop_in     = 1'b0;
                  remain_base = '0;
                  done        = 1'b1;
               end else begin
                  remain_base = mag;
                  moving_in   = 1'b1;
                  do_step     = since_ff >= cfg.delay;
               end
            end
         end
         stp_pkg::REQ_TICK: begin
            since_base = since_inc;
            do_step    = moving_ff && (since_inc >= cfg.delay);
         end
         stp_pkg::REQ_STOP: begin
            if (moving_ff) begin
               moving_in   = 1'b0;
               remain_base = '0;
               done        = 1'b1;
            end else begin
               stop_in = 1'b1;
            end
         end
         default: ;
      endcase

      // positions left out of range by a register change wrap as well
      fwd_wrap  = pos_ff >= cfg.rev_last;
      back_wrap = (pos_ff == '0) || (pos_ff > cfg.rev_last);

      pos_in    = pos_ff;
      m10_in    = m10_ff;
      since_in  = since_base;
      remain_in = remain_base;
      taken_in  = taken_base;
      if (do_step) begin
         if (fwd_in) begin
            pos_in = fwd_wrap ? '0 : pos_ff + stp_pkg::POS_W'(1);
            if (fwd_wrap || m10_ff == stp_pkg::PHASE_TEN_LAST)
               m10_in = '0;
            else
               m10_in = m10_ff + stp_pkg::PHASE_W'(1);
         end else begin
            pos_in = back_wrap ? cfg.rev_last : pos_ff - stp_pkg::POS_W'(1);
            if (back_wrap)
               m10_in = cfg.rev_last_m10;
            else if (m10_ff == '0)
               m10_in = stp_pkg::PHASE_TEN_LAST;
            else
               m10_in = m10_ff - stp_pkg::PHASE_W'(1);
         end
         since_in  = '0;
         remain_in = remain_base - stp_pkg::CNT_W'(1);
         taken_in  = taken_base + stp_pkg::CNT_W'(1);
         if (remain_in == '0) begin
            moving_in = 1'b0;
            done      = 1'b1;
         end
      end

      count16         = {1'b0, taken_in};
      rsp.stepped     = do_step;
      rsp.phase       = cfg.five_wire ? m10_in : {2'b00, pos_in[1:0]};
      rsp.forward     = fwd_in;
      rsp.move_done   = done;
      rsp.moved_count = !done ? '0 : (fwd_in ? count16 : stp_pkg::POS_W'(0) - count16);
      rsp_hit         = do_step || done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         m10_ff    <= '0;
         remain_ff <= '0;
         taken_ff  <= '0;
         fwd_ff    <= 1'b0;
         since_ff  <= '0;
         moving_ff <= 1'b0;
         stop_ff   <= 1'b0;
      end else if (fire) begin
         pos_ff    <= pos_in;
         m10_ff    <= m10_in;
         remain_ff <= remain_in;
         taken_ff  <= taken_in;
         fwd_ff    <= fwd_in;
         since_ff  <= since_in;
         moving_ff <= moving_in;
         stop_ff   <= stop_in;
      end
   end

endmodule

/* design/timed_stepper_move_with_abort.sv */
// Top level of the stepper move pacer: request register, state, result register.
//
// Request channel (req_): move command, one-microsecond tick or stop request,
// with a signed step count used by moves. A transfer happens when req_valid
// is high and req_stall is low.
// Result channel (rsp_): one result per request that steps or ends a move;
// ticks and other requests that do neither give no result.
// Config channel (csr_): index/data writes, always ready; write only while
// the block is idle.
// A request taken enters the request register; its result is written into the
// result register when it fires. Throughput: one request per cycle unless a
// result is stalled; the state update is a single pass of counter increments
// and compares on the registered request.
// Reset (synchronous): registers go to their defaults, the position, counts
// and timer clear, and both pipeline registers empty.
// Receiver stall: the result holds; the request register holds behind it and
// req_stall rises only while both registers are full.
module timed_stepper_move_with_abort (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic signed [stp_pkg::POS_W-1:0]  req_move_steps,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_stepped,
   output logic [stp_pkg::PHASE_W-1:0]       rsp_phase,
   output logic                              rsp_forward,
   output logic                              rsp_move_done,
   output logic signed [stp_pkg::POS_W-1:0]  rsp_moved_count,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [stp_pkg::CSR_W-1:0]         csr_data
);

   logic                      in_valid_ff;
   logic [1:0]                in_type_ff;
   logic [stp_pkg::POS_W-1:0] in_steps_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   stp_pkg::stp_rsp_type      rsp_ff;
   stp_pkg::stp_rsp_type      rsp_next;
   stp_pkg::stp_cfg_type      cfg;
   logic                      rsp_hit;
   logic                      advance;
   logic                      fire;

   assign csr_ready = 1'b1;

   stp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   stp_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .req_type  (in_type_ff),
      .req_steps (in_steps_ff),
      .cfg       (cfg),
      .rsp       (rsp_next),
      .rsp_hit   (rsp_hit)
   );

   always_comb begin
      if (fire && rsp_hit)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall)
            in_valid_ff <= req_valid;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_type_ff  <= req_type;
         in_steps_ff <= req_move_steps;
      end
      if (fire && rsp_hit)
         rsp_ff <= rsp_next;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_stepped     = rsp_ff.stepped;
   assign rsp_phase       = rsp_ff.phase;
   assign rsp_forward     = rsp_ff.forward;
   assign rsp_move_done   = rsp_ff.move_done;
   assign rsp_moved_count = rsp_ff.moved_count;

endmodule

/* design/stp_checker.sv */
// Port-level checks for the stepper move pacer, bound to the top level.
module stp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_stepped,
   input logic [stp_pkg::PHASE_W-1:0]       rsp_phase,
   input logic                              rsp_move_done,
   input logic signed [stp_pkg::POS_W-1:0]  rsp_moved_count
);

   // a stalled result stays presented, with its count, phase and done flag unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_moved_count)
         && $stable(rsp_phase) && $stable(rsp_move_done))
      else $error("result changed while stalled");

   a_rsp_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_stepped || rsp_move_done)
      else $error("result with neither a step nor a move end");

   a_count_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_move_done |-> rsp_moved_count == '0)
      else $error("moved count nonzero without move end");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_phase <= stp_pkg::PHASE_TEN_LAST)
      else $error("phase out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind timed_stepper_move_with_abort stp_checker u_stp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_stepped     (rsp_stepped),
   .rsp_phase       (rsp_phase),
   .rsp_move_done   (rsp_move_done),
   .rsp_moved_count (rsp_moved_count)
);
